FILE: rtl/sqd_pkg.sv
`default_nettype none

package sqd_pkg;

  localparam int QIDX_W = 3;
  localparam int QCNT_W = 3;
  localparam int TIME_W = 32;
  localparam int PEOPLE_W = 16;
  localparam int WAIT_W = 64;
  localparam int ARR_W = 32;
  localparam int PROD_W = PEOPLE_W + TIME_W;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef enum logic [1:0] {
    OP_ARRIVAL = 2'd0,
    OP_START   = 2'd1,
    OP_END     = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  // Register index as decoded from paddr[2].
  localparam logic REG_QUEUE_COUNT = 1'b0;
  localparam logic REG_RESERVED    = 1'b1;

  localparam logic [QCNT_W-1:0] QUEUE_COUNT_RESET = 3'd5;

  typedef struct packed {
    logic              found;
    logic [QIDX_W-1:0] best;
  } pick_t;

endpackage

`default_nettype wire

FILE: rtl/sqd_pick.sv
`default_nettype none

module sqd_pick #(
  parameter int NUM_QUEUES = 5,
  parameter int LEN_W = 5
) (
  input  wire logic [sqd_pkg::QCNT_W-1:0]        queue_count,
  input  wire logic                              reserved,
  input  wire logic                              flagged,
  input  wire logic [NUM_QUEUES-1:0]             full,
  input  wire logic [NUM_QUEUES-1:0][LEN_W-1:0]  lens,
  output sqd_pkg::pick_t                         pick
);
  import sqd_pkg::*;

  localparam int IW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int LVL = $clog2(NUM_QUEUES);
  localparam int P = 1 << LVL;
  localparam int NODES = 2 * P - 1;

  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] len;
    logic [IW-1:0]    idx;
  } node_t;

  node_t node [NODES];

  // Leaves: a queue competes when it is in use, not full, and of the right class.
  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < NUM_QUEUES) begin : g_real
      logic elig;
      assign elig = (32'(queue_count) > i) &&
                    ((reserved && flagged) ? (i == 0) : (!reserved || (i != 0)));
      assign node[P-1+i] = '{ok: elig & ~full[i], len: lens[i], idx: IW'(i)};
    end else begin : g_pad
      assign node[P-1+i] = '{ok: 1'b0, len: '0, idx: '0};
    end
  end

  // The left child holds lower indices, so it wins ties.
  for (genvar k = 0; k < P - 1; k++) begin : g_node
    assign node[k] = (node[2*k+1].ok && (!node[2*k+2].ok || node[2*k+1].len <= node[2*k+2].len))
                     ? node[2*k+1] : node[2*k+2];
  end

  assign pick.found = node[0].ok;
  assign pick.best = QIDX_W'(node[0].idx);

endmodule

`default_nettype wire

FILE: rtl/shortest_queue_dispatcher.sv
`default_nettype none

// Join-shortest-queue dispatcher over NUM_QUEUES ring-buffer queues.
// An item is an event (arrival, service start, service end) presented on
// opcode, event_time, queue_index and flagged_arrival; it is taken at a
// rising edge where start is high and busy is low.
// Each item gives one result, shown for one cycle with done high. The result
// passes through the execute and finish states and is then registered onto the
// outputs; busy is high only in the execute state, so a new item can be taken while the last one finishes.
// This follows from the registered read of the entry memory: the pointer
// update and the memory access happen in the execute state, and the dequeued
// word and the wait-sum addition are folded in during the finish state,
// overlapped with the next item's acceptance.
// The receiver cannot stall; results must be taken as they come.
// Reset clears the pointers, full marks, server flags and counters and sets
// queue_count to 5, reserved_queue_enable to 0. The entry memory is not
// cleared; only written entries are ever read.
// Configuration goes through the APB port: queue_count at 0x0, the reserved
// queue enable at 0x4. Write it only while no item is in flight.
module shortest_queue_dispatcher #(
  parameter int NUM_QUEUES = 5,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode,
  input  wire logic [sqd_pkg::TIME_W-1:0]    event_time,
  input  wire logic [sqd_pkg::QIDX_W-1:0]    queue_index,
  input  wire logic                          flagged_arrival,
  output logic                               done,
  output logic                               placed,
  output logic                               rejected_full,
  output logic [sqd_pkg::QIDX_W-1:0]         chosen_queue,
  output logic                               request_start,
  output logic [sqd_pkg::TIME_W-1:0]         dequeued_time,
  output logic                               empty_refused,
  output logic [sqd_pkg::PEOPLE_W-1:0]       people_in_system,
  output logic [sqd_pkg::WAIT_W-1:0]         accumulated_wait,
  output logic [sqd_pkg::ARR_W-1:0]          arrivals_counted,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sqd_pkg::APB_AW-1:0]    paddr,
  input  wire logic [sqd_pkg::APB_DW-1:0]    pwdata,
  output logic [sqd_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import sqd_pkg::*;

  localparam int IW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW = (MEM_D > 1) ? $clog2(MEM_D) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [QCNT_W-1:0] queue_count;
  logic              reserved_queue_enable;

  // Captured item.
  opcode_t           op;
  logic [TIME_W-1:0] ev_time;
  logic [QIDX_W-1:0] qi;
  logic              flag;

  // Queue and server state.
  logic [PW-1:0]     head [NUM_QUEUES];
  logic [PW-1:0]     tail [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] full;
  logic [NUM_QUEUES-1:0] sbusy;
  logic [NUM_QUEUES-1:0] empty;
  logic [NUM_QUEUES-1:0][LEN_W-1:0] lens;

  logic [PEOPLE_W-1:0] people_count;
  logic [WAIT_W-1:0]   wait_total;
  logic [ARR_W-1:0]    arrival_total;
  logic [TIME_W-1:0]   previous_time;

  // Results carried from the execute cycle to the finish cycle.
  logic              p_placed;
  logic              p_rejected;
  logic [QIDX_W-1:0] p_chosen;
  logic              p_req;
  logic              p_refused;
  logic              p_pop;
  logic [PROD_W-1:0] product;

  // Entry memory.
  logic [TIME_W-1:0] mem [MEM_D];
  logic [TIME_W-1:0] rdata;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;

  pick_t             pick;
  logic [IW-1:0]     best_q;
  logic [IW-1:0]     qi_q;
  logic              qi_ok;
  logic [TIME_W-1:0] elapsed;
  logic              cfg_wr;
  logic              accept;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign busy = (state == S_EXEC);
  assign accept = start & ~busy;

  always_comb begin
    case (paddr[2])
      REG_QUEUE_COUNT: prdata = APB_DW'(queue_count);
      REG_RESERVED:    prdata = APB_DW'(reserved_queue_enable);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_count <= QUEUE_COUNT_RESET;
      reserved_queue_enable <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_QUEUE_COUNT: queue_count <= pwdata[QCNT_W-1:0];
        REG_RESERVED:    reserved_queue_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_QUEUES; i++) begin : g_len
    assign empty[i] = ~full[i] && (head[i] == tail[i]);
    assign lens[i] = full[i] ? LEN_W'(QUEUE_DEPTH)
                   : (LEN_W'(tail[i]) - LEN_W'(head[i]) +
                      ((tail[i] < head[i]) ? LEN_W'(QUEUE_DEPTH) : LEN_W'(0)));
  end

  sqd_pick #(
    .NUM_QUEUES(NUM_QUEUES),
    .LEN_W(LEN_W)
  ) u_pick (
    .queue_count(queue_count),
    .reserved(reserved_queue_enable),
    .flagged(flag),
    .full(full),
    .lens(lens),
    .pick(pick)
  );

  assign best_q = IW'(pick.best);
  assign qi_q = IW'(qi);
  assign qi_ok = (32'(qi) < NUM_QUEUES);
  assign elapsed = (ev_time >= previous_time) ? (ev_time - previous_time) : '0;

  assign mem_we = (state == S_EXEC) && (op == OP_ARRIVAL) && pick.found;
  assign mem_re = (state == S_EXEC) && (op == OP_START) && qi_ok && !empty[qi_q];
  assign waddr = AW'(32'(best_q) * 32'(QUEUE_DEPTH) + 32'(tail[best_q]));
  assign raddr = AW'(32'(qi_q) * 32'(QUEUE_DEPTH) + 32'(head[qi_q]));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= ev_time;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: state_next = S_FIN;
      S_FIN:  state_next = accept ? S_EXEC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= opcode_t'(opcode);
      ev_time <= event_time;
      qi <= queue_index;
      flag <= flagged_arrival;
    end
  end

  // Execute cycle: pointer and counter updates, memory access.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
      full <= '0;
      sbusy <= '0;
      people_count <= '0;
      arrival_total <= '0;
      previous_time <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        if (op != OP_NONE) begin
          previous_time <= ev_time;
        end
        case (op)
          OP_ARRIVAL: begin
            arrival_total <= arrival_total + 1'b1;
            if (people_count != '1) begin
              people_count <= people_count + 1'b1;
            end
            if (pick.found) begin
              logic [PW-1:0] t_next;
              t_next = (tail[best_q] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail[best_q] + 1'b1;
              tail[best_q] <= t_next;
              if (t_next == head[best_q]) begin
                full[best_q] <= 1'b1;
              end
            end
          end
          OP_START: begin
            if (people_count != '0) begin
              people_count <= people_count - 1'b1;
            end
            if (mem_re) begin
              head[qi_q] <= (head[qi_q] == PW'(QUEUE_DEPTH - 1)) ? '0 : head[qi_q] + 1'b1;
              full[qi_q] <= 1'b0;
              sbusy[qi_q] <= 1'b1;
            end
          end
          OP_END: begin
            if (qi_ok) begin
              sbusy[qi_q] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      product <= (op != OP_NONE) ? PROD_W'(people_count) * PROD_W'(elapsed) : '0;
      p_placed <= 1'b0;
      p_rejected <= 1'b0;
      p_chosen <= '0;
      p_req <= 1'b0;
      p_refused <= 1'b0;
      p_pop <= mem_re;
      case (op)
        OP_ARRIVAL: begin
          p_placed <= pick.found;
          p_rejected <= ~pick.found;
          p_chosen <= pick.found ? pick.best : '0;
          p_req <= pick.found & ~sbusy[best_q];
        end
        OP_START: begin
          p_chosen <= qi;
          p_refused <= ~mem_re;
        end
        OP_END: begin
          p_chosen <= qi;
          p_req <= qi_ok;
        end
        default: ;
      endcase
    end
  end

  // Finish cycle: fold in the product and the dequeued word.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      wait_total <= '0;
    end else begin
      done <= (state == S_FIN);
      if (state == S_FIN) begin
        wait_total <= wait_total + WAIT_W'(product);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      placed <= p_placed;
      rejected_full <= p_rejected;
      chosen_queue <= p_chosen;
      request_start <= p_req;
      dequeued_time <= p_pop ? rdata : '0;
      empty_refused <= p_refused;
      people_in_system <= people_count;
      accumulated_wait <= wait_total + WAIT_W'(product);
      arrivals_counted <= arrival_total;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    busy |=> ##1 done)
    else $error("result strobe missing two cycles after accept");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(placed && rejected_full) && !(placed && empty_refused))
    else $error("conflicting result flags");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && (op == OP_START) && mem_re |=> !full[$past(qi_q)])
    else $error("queue still marked full after a dequeue");
`endif

endmodule

`default_nettype wire

FILE: tb/shortest_queue_dispatcher_tb.sv
`timescale 1ns / 100ps

module shortest_queue_dispatcher_tb;
  import sqd_pkg::*;

  localparam int NUM_QUEUES = 5;
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CLK_PERIOD = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_SETTING = 100;
  localparam int SOAK_ITEMS = 180;
  localparam int SETTINGS_USED = 10;
  localparam int MAX_REPORTS = 100;
  localparam logic [APB_AW-1:0] ADDR_QUEUE_COUNT = {REG_QUEUE_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_RESERVED = {REG_RESERVED, 2'b00};
  localparam int PHASE_QUEUES [SETTINGS_USED] = '{5, 3, 1, 7, 2, 5, 6, 1, 0, 4};
  localparam int PHASE_RESERVE [SETTINGS_USED] = '{0, 1, 0, 1, 0, 1, 0, 1, 1, 0};

  typedef struct packed {
    logic                placed;
    logic                rejected;
    logic [QIDX_W-1:0]   chosen;
    logic                request;
    logic [TIME_W-1:0]   dequeued;
    logic                refused;
    logic [PEOPLE_W-1:0] people;
    logic [WAIT_W-1:0]   acc_wait;
    logic [ARR_W-1:0]    arrivals;
  } outcome_t;

  class dispatch_scoreboard;
    logic [TIME_W-1:0]   slot_time [NUM_QUEUES][QUEUE_DEPTH];
    logic [PTR_W-1:0]    rd_ptr [NUM_QUEUES];
    logic [PTR_W-1:0]    wr_ptr [NUM_QUEUES];
    bit                  is_full [NUM_QUEUES];
    bit                  srv_busy [NUM_QUEUES];
    logic [PEOPLE_W-1:0] population;
    logic [WAIT_W-1:0]   wait_sum;
    logic [ARR_W-1:0]    arrival_cnt;
    logic [TIME_W-1:0]   last_time;
    logic [QCNT_W-1:0]   active_queues;
    bit                  reserve_q0;
    outcome_t            expected_outcomes [$];
    int unsigned         mismatches, events, placed_cnt, turned_away, refused_cnt;
    bit                  saturated, wrapped;

    function new();
      for (int q = 0; q < NUM_QUEUES; q++) begin
        rd_ptr[q] = '0;
        wr_ptr[q] = '0;
        is_full[q] = 0;
        srv_busy[q] = 0;
      end
      population = '0;
      wait_sum = '0;
      arrival_cnt = '0;
      last_time = '0;
      active_queues = QUEUE_COUNT_RESET;
      reserve_q0 = 0;
    endfunction

    function void write_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      if (addr == ADDR_QUEUE_COUNT) active_queues = data[QCNT_W-1:0];
      else if (addr == ADDR_RESERVED) reserve_q0 = data[0];
    endfunction

    function int fill_level(int q);
      logic [PTR_W-1:0] diff;
      if (is_full[q]) return QUEUE_DEPTH;
      diff = wr_ptr[q] - rd_ptr[q];
      return diff;
    endfunction

    function void note_event(opcode_t op, logic [TIME_W-1:0] t, logic [QIDX_W-1:0] qi,
                             logic flag);
      outcome_t o;
      logic [WAIT_W-1:0] elapsed, weight, prev_sum;
      int n, best, shortest, first;
      bit found;
      o = '0;
      found = 0;
      best = 0;
      if (op != OP_NONE) begin
        // Time running backwards contributes nothing but still moves the reference.
        elapsed = (t >= last_time) ? t - last_time : '0;
        weight = population;
        prev_sum = wait_sum;
        wait_sum = wait_sum + weight * elapsed;
        if (wait_sum < prev_sum) wrapped = 1;
        last_time = t;
      end
      case (op)
        OP_ARRIVAL: begin
          n = (active_queues < NUM_QUEUES) ? active_queues : NUM_QUEUES;
          arrival_cnt++;
          if (population != '1) population++;
          if (population == '1) saturated = 1;
          if (reserve_q0 && flag) begin
            if (n >= 1 && !is_full[0]) found = 1;
          end else begin
            shortest = QUEUE_DEPTH;
            first = reserve_q0 ? 1 : 0;
            for (int i = first; i < n; i++) begin
              if (fill_level(i) < shortest) begin
                shortest = fill_level(i);
                best = i;
                found = 1;
              end
            end
          end
          if (found) begin
            slot_time[best][wr_ptr[best]] = t;
            wr_ptr[best]++;
            if (wr_ptr[best] == rd_ptr[best]) is_full[best] = 1;
            o.placed = 1;
            o.chosen = best[QIDX_W-1:0];
            o.request = !srv_busy[best];
            placed_cnt++;
          end else begin
            o.rejected = 1;
            turned_away++;
          end
        end
        OP_START: begin
          if (population != 0) population--;
          o.chosen = qi;
          if (qi < NUM_QUEUES && fill_level(qi) != 0) begin
            o.dequeued = slot_time[qi][rd_ptr[qi]];
            is_full[qi] = 0;
            rd_ptr[qi]++;
            srv_busy[qi] = 1;
          end else begin
            o.refused = 1;
            refused_cnt++;
          end
        end
        OP_END: begin
          o.chosen = qi;
          if (qi < NUM_QUEUES) begin
            srv_busy[qi] = 0;
            o.request = 1;
          end
        end
        default: ;
      endcase
      o.people = population;
      o.acc_wait = wait_sum;
      o.arrivals = arrival_cnt;
      expected_outcomes.push_back(o);
      events++;
    endfunction

    function void compare(string field, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result arrived with nothing expected, expected none, actual %h",
                   $time, got);
        mismatches++;
        return;
      end
      want = expected_outcomes.pop_front();
      compare("placed", want.placed, got.placed);
      compare("rejected_full", want.rejected, got.rejected);
      compare("chosen_queue", want.chosen, got.chosen);
      compare("request_start", want.request, got.request);
      compare("dequeued_time", want.dequeued, got.dequeued);
      compare("empty_refused", want.refused, got.refused);
      compare("people_in_system", want.people, got.people);
      compare("accumulated_wait", want.acc_wait, got.acc_wait);
      compare("arrivals_counted", want.arrivals, got.arrivals);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = OP_NONE;
  logic [TIME_W-1:0] event_time = '0;
  logic [QIDX_W-1:0] queue_index = '0;
  logic flagged_arrival = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;

  logic busy, done, placed, rejected_full, request_start, empty_refused, pready;
  logic [QIDX_W-1:0] chosen_queue;
  logic [TIME_W-1:0] dequeued_time;
  logic [PEOPLE_W-1:0] people_in_system;
  logic [WAIT_W-1:0] accumulated_wait;
  logic [ARR_W-1:0] arrivals_counted;
  logic [APB_DW-1:0] prdata;

  dispatch_scoreboard sb;
  outcome_t observed;
  logic [TIME_W-1:0] sim_clock = '0;
  int stall_cycles = 0;

  shortest_queue_dispatcher #(
    .NUM_QUEUES(NUM_QUEUES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .event_time(event_time),
    .queue_index(queue_index),
    .flagged_arrival(flagged_arrival),
    .done(done),
    .placed(placed),
    .rejected_full(rejected_full),
    .chosen_queue(chosen_queue),
    .request_start(request_start),
    .dequeued_time(dequeued_time),
    .empty_refused(empty_refused),
    .people_in_system(people_in_system),
    .accumulated_wait(accumulated_wait),
    .arrivals_counted(arrivals_counted),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      observed.placed = placed;
      observed.rejected = rejected_full;
      observed.chosen = chosen_queue;
      observed.request = request_start;
      observed.dequeued = dequeued_time;
      observed.refused = empty_refused;
      observed.people = people_in_system;
      observed.acc_wait = accumulated_wait;
      observed.arrivals = arrivals_counted;
      sb.check_outcome(observed);
    end
  end

  // Any accepted item or result restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("shortest_queue_dispatcher_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_event(opcode_t op, logic [TIME_W-1:0] t, logic [QIDX_W-1:0] qi,
                            logic flag);
    start <= 1'b1;
    opcode <= op;
    event_time <= t;
    queue_index <= qi;
    flagged_arrival <= flag;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_event(op, t, qi, flag);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    opcode <= 2'($urandom);
    event_time <= $urandom;
    queue_index <= QIDX_W'($urandom);
    flagged_arrival <= 1'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.expected_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Upper bits of each word are random; only the low field should matter.
  task automatic apply_setting(int queues, bit reserve);
    logic [APB_DW-1:0] word;
    drain_results();
    word = $urandom;
    word[QCNT_W-1:0] = QCNT_W'(queues);
    write_register(ADDR_QUEUE_COUNT, word);
    word = $urandom;
    word[0] = reserve;
    write_register(ADDR_RESERVED, word);
  endtask

  task automatic run_random(int items, int arrival_pct, int idle_pct);
    int r;
    opcode_t op;
    logic [TIME_W-1:0] t;
    logic [QIDX_W-1:0] qi;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_NONE;
      else if (r < 3 + arrival_pct) op = OP_ARRIVAL;
      else if ($urandom_range(0, 4) < 3) op = OP_START;
      else op = OP_END;
      qi = ($urandom_range(0, 19) == 0) ? QIDX_W'($urandom_range(NUM_QUEUES, 7))
                                         : QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
      case ($urandom_range(0, 31))
        0: begin
          t = $urandom;
          sim_clock = t;
        end
        1: t = sim_clock - $urandom_range(1, 1000);
        default: begin
          sim_clock = sim_clock + $urandom_range(0, 40);
          t = sim_clock;
        end
      endcase
      send_event(op, t, qi, 1'($urandom_range(0, 1)));
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        pause_sender($urandom_range(1, 11));
    end
  endtask

  // Mostly arrivals with times swinging between low values and the top of the
  // range, so the queues fill up and the wait sum takes very large steps.
  task automatic run_soak(int items);
    int r;
    opcode_t op;
    logic [TIME_W-1:0] t;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 31);
      if (r == 0) op = OP_START;
      else if (r == 1) op = OP_END;
      else op = OP_ARRIVAL;
      t = k[0] ? '1 : TIME_W'($urandom_range(0, 255));
      send_event(op, t, QIDX_W'($urandom_range(0, NUM_QUEUES - 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int idle_pct;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed events, first under the reset configuration and then under three other register settings.
    send_event(OP_START, 32'd10, 3'd0, 1'b0);
    send_event(OP_END, 32'd20, 3'd4, 1'b0);
    send_event(OP_START, 32'd30, 3'd7, 1'b1);
    send_event(OP_END, 32'd40, 3'd5, 1'b0);
    send_event(OP_NONE, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_event(OP_ARRIVAL, 32'd100, 3'd0, 1'b0);
    send_event(OP_ARRIVAL, 32'd50, 3'd6, 1'b1);
    send_event(OP_ARRIVAL, 32'd150, 3'd0, 1'b0);
    send_event(OP_ARRIVAL, 32'd160, 3'd0, 1'b0);
    send_event(OP_ARRIVAL, 32'd170, 3'd0, 1'b0);
    send_event(OP_ARRIVAL, 32'd180, 3'd0, 1'b0);
    send_event(OP_START, 32'd200, 3'd0, 1'b0);
    send_event(OP_ARRIVAL, 32'd210, 3'd0, 1'b0);
    send_event(OP_START, 32'd220, 3'd0, 1'b0);
    send_event(OP_END, 32'd230, 3'd0, 1'b0);
    send_event(OP_START, 32'd240, 3'd3, 1'b0);
    send_event(OP_ARRIVAL, 32'hFFFF_FFFF, 3'd2, 1'b0);
    send_event(OP_ARRIVAL, 32'd0, 3'd1, 1'b1);
    apply_setting(1, 1'b1);
    send_event(OP_ARRIVAL, 32'd300, 3'd0, 1'b1);
    send_event(OP_ARRIVAL, 32'd310, 3'd0, 1'b0);
    send_event(OP_START, 32'd320, 3'd4, 1'b0);
    apply_setting(0, 1'b0);
    send_event(OP_ARRIVAL, 32'd330, 3'd0, 1'b0);
    send_event(OP_START, 32'd340, 3'd2, 1'b0);
    apply_setting(7, 1'b0);
    send_event(OP_ARRIVAL, 32'd350, 3'd0, 1'b1);
    sim_clock = 32'd400;

    for (int p = 0; p < SETTINGS_USED; p++) begin
      apply_setting(PHASE_QUEUES[p], 1'(PHASE_RESERVE[p]));
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 50;
      endcase
      run_random(ITEMS_PER_SETTING, $urandom_range(30, 75), idle_pct);
    end

    apply_setting(5, 1'b0);
    run_soak(SOAK_ITEMS);

    drain_results();
    repeat (8) @(posedge clk);

    $display("Checked %0d events over %0d register settings: %0d placed, %0d turned away,",
             sb.events, SETTINGS_USED + 4, sb.placed_cnt, sb.turned_away);
    $display("%0d starts refused; population ceiling reached: %0d, wait sum wrapped: %0d.",
             sb.refused_cnt, sb.saturated, sb.wrapped);
    if (sb.mismatches == 0 && sb.expected_outcomes.size() == 0) begin
      $display("shortest_queue_dispatcher_tb: done, clean");
    end else begin
      $display("shortest_queue_dispatcher_tb: done, errors");
    end
    $finish;
  end

endmodule
